// File: hdl/orb_pkg.sv
// Shared types, commands and constants of the overwrite ring buffer.
`timescale 1ns / 1ps

package orb_pkg;

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int POS_W  = 9;
    localparam int PROD_W = 16;
    localparam int NEED_W = 14;
    localparam int BITS_PER_BYTE_SHIFT = 3;

    // Store depth default and length register reset value
    localparam int DEPTH_DEFAULT = 256;
    localparam int LEN_RESET     = 255;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_SETPOS = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               command;
        logic [BYTE_W-1:0]  write_byte;
        logic [POS_W-1:0]   position;
        logic [BYTE_W-1:0]  header_count;
        logic [BYTE_W-1:0]  item_count;
        logic [BYTE_W-1:0]  item_bits;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_data;
        logic               read_valid;
        logic               not_empty;
        logic               enough_data;
        logic               full_res;
    } out_item_t;

    // Status of the remainder unit as seen by the core
    typedef struct packed {
        logic busy;
        logic done;
    } rem_stat_t;

endpackage

// File: hdl/orb_in_if.sv
// Command channel interface: valid, ready and one command item.
`timescale 1ns / 1ps

interface orb_in_if;
    import orb_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// File: hdl/orb_out_if.sv
// Result channel interface: valid, ready and one result item.
`timescale 1ns / 1ps

interface orb_out_if;
    import orb_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// File: hdl/orb_in_stage.sv
// Input register of the ring buffer: holds one accepted command item.
`timescale 1ns / 1ps

module orb_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    orb_in_if.sink            cmd_ch,
    input  logic              take,
    output logic              item_valid,
    output orb_pkg::in_item_t item
);
    import orb_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    // Accept whenever the register is empty or drains this cycle
    assign cmd_ch.ready = !valid_reg || take;
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign valid_next   = accept || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd_ch.item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hdl/orb_rem_unit.sv
// Bit-serial remainder unit: position modulo buffer length, one bit a cycle.
`timescale 1ns / 1ps

module orb_rem_unit #(
    parameter int STORE_DEPTH = orb_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 clear,
    input  logic [orb_pkg::POS_W-1:0]            dividend,
    input  logic [$clog2(STORE_DEPTH+1)-1:0]     divisor,
    output logic [$clog2(STORE_DEPTH+1)-1:0]     remainder,
    output orb_pkg::rem_stat_t                   status
);
    import orb_pkg::*;

    localparam int LEN_W = $clog2(STORE_DEPTH + 1);
    localparam int CNT_W = $clog2(POS_W + 1);

    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] rem_next;
    logic [POS_W-1:0] shift_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   trial_sub;

    // Shift in the next dividend bit and subtract the divisor when it fits
    always_comb
    begin
        trial     = {rem_reg, shift_reg[POS_W-1]};
        trial_sub = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = trial_sub[LEN_W-1:0];
        end
        else
        begin
            rem_next = trial[LEN_W-1:0];
        end
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(POS_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else if (clear)
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            shift_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= shift_reg << 1;
        end
    end

    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

`ifndef SYNTHESIS
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0) && (cnt_reg <= CNT_W'(POS_W)))
        else $error("remainder unit busy with bad bit count");

    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("remainder unit busy and done together");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < divisor))
        else $error("remainder not below divisor");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("remainder unit did not start");
`endif

endmodule

// File: hdl/orb_core.sv
// Ring buffer core: indices, full flag, byte store and result register.
`timescale 1ns / 1ps

module orb_core #(
    parameter int STORE_DEPTH = orb_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [orb_pkg::BYTE_W-1:0]           cfg_data,
    input  logic                                 item_valid,
    input  orb_pkg::in_item_t                    item,
    output logic                                 take,
    output logic                                 rem_start,
    output logic [$clog2(STORE_DEPTH+1)-1:0]     divisor,
    input  logic [$clog2(STORE_DEPTH+1)-1:0]     rem_value,
    input  orb_pkg::rem_stat_t                   rem_status,
    orb_out_if.source                            res_ch
);
    import orb_pkg::*;

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int LEN_W = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W = POS_W + 1;
    localparam int LEN_INIT = (LEN_RESET > STORE_DEPTH) ? STORE_DEPTH : LEN_RESET;

    // Architectural state
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_cfg;
    logic [IDX_W-1:0]  wr_reg;
    logic [IDX_W-1:0]  wr_next;
    logic [IDX_W-1:0]  rd_reg;
    logic [IDX_W-1:0]  rd_next;
    logic              full_reg;
    logic              full_next;
    logic [BYTE_W-1:0] store_mem [STORE_DEPTH];

    // Result register
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         res_reg;

    // Step logic
    logic              fire;
    logic              out_free;
    logic              store_we;
    logic              rvalid_next;
    logic              not_empty_next;
    logic              enough_next;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  len_x;
    logic [CMP_W-1:0]  pos_diff;
    logic              pos_wrap;
    logic              pos_slow;
    logic              need_rem;
    logic [IDX_W-1:0]  target;
    logic [IDX_W-1:0]  wr_inc;
    logic [IDX_W-1:0]  rd_inc;
    logic [IDX_W-1:0]  tgt_inc;
    logic [LEN_W-1:0]  distance;
    logic [PROD_W-1:0] prod;
    logic [NEED_W-1:0] need;

    // Advance an index with wrap at the buffer length
    function automatic logic [IDX_W-1:0] next_idx(
        input logic [IDX_W-1:0] idx,
        input logic [LEN_W-1:0] len
    );
        logic [LEN_W-1:0] inc;
        inc = LEN_W'(idx) + LEN_W'(1);
        if (inc >= len)
        begin
            return '0;
        end
        return inc[IDX_W-1:0];
    endfunction

    // Clamp a written length into 1..STORE_DEPTH
    always_comb
    begin
        if (int'(cfg_data) > STORE_DEPTH)
        begin
            len_cfg = LEN_W'(STORE_DEPTH);
        end
        else if (cfg_data == '0)
        begin
            len_cfg = LEN_W'(1);
        end
        else
        begin
            len_cfg = LEN_W'(cfg_data);
        end
    end

    // Wrap the new write position: one subtract, or the remainder unit
    assign pos_x    = CMP_W'(item.position);
    assign len_x    = CMP_W'(len_reg);
    assign pos_diff = pos_x - len_x;
    assign pos_wrap = pos_x >= len_x;
    assign pos_slow = pos_wrap && (pos_diff >= len_x);

    always_comb
    begin
        if (!pos_wrap)
        begin
            target = pos_x[IDX_W-1:0];
        end
        else if (pos_slow)
        begin
            target = rem_value[IDX_W-1:0];
        end
        else
        begin
            target = pos_diff[IDX_W-1:0];
        end
    end

    // Step an item when the result register is free and the remainder is ready
    assign need_rem  = (item.command == CMD_SETPOS) && pos_slow;
    assign out_free  = !out_valid_reg || res_ch.ready;
    assign fire      = item_valid && out_free && (!need_rem || rem_status.done);
    assign take      = fire;
    assign rem_start = item_valid && need_rem && !rem_status.busy && !rem_status.done;
    assign divisor   = len_reg;

    assign wr_inc  = next_idx(wr_reg, len_reg);
    assign rd_inc  = next_idx(rd_reg, len_reg);
    assign tgt_inc = next_idx(target, len_reg);

    // Decode the command into next indices and flag
    always_comb
    begin
        wr_next     = wr_reg;
        rd_next     = rd_reg;
        full_next   = full_reg;
        rvalid_next = 1'b0;
        store_we    = 1'b0;
        unique case (item.command)
            CMD_WRITE:
            begin
                store_we = 1'b1;
                wr_next  = wr_inc;
                if (rd_reg == wr_inc)
                begin
                    full_next = 1'b1;
                end
                if (full_next)
                begin
                    rd_next = wr_inc;
                end
            end
            CMD_READ:
            begin
                if (rd_reg == wr_reg)
                begin
                    if (full_reg)
                    begin
                        full_next   = 1'b0;
                        rvalid_next = 1'b1;
                        rd_next     = rd_inc;
                    end
                end
                else
                begin
                    rvalid_next = 1'b1;
                    rd_next     = rd_inc;
                end
            end
            CMD_SETPOS:
            begin
                if (pos_wrap)
                begin
                    if ((rd_reg < target) || (rd_reg >= wr_reg))
                    begin
                        rd_next = tgt_inc;
                    end
                end
                else if ((rd_reg < target) && (rd_reg >= wr_reg))
                begin
                    rd_next = tgt_inc;
                end
                wr_next = target;
            end
            CMD_STATUS:
            begin
                wr_next = wr_reg;
            end
            default:
            begin
                wr_next = wr_reg;
            end
        endcase
    end

    // Distance between indices and the frame size check
    always_comb
    begin
        if (wr_next >= rd_next)
        begin
            distance = LEN_W'(wr_next) - LEN_W'(rd_next);
        end
        else
        begin
            distance = len_reg - LEN_W'(rd_next) + LEN_W'(wr_next);
        end
        prod           = PROD_W'(item.item_count) * PROD_W'(item.item_bits);
        need           = NEED_W'(item.header_count)
                       + NEED_W'(prod >> BITS_PER_BYTE_SHIFT);
        enough_next    = NEED_W'(distance) >= need;
        not_empty_next = !((rd_next == wr_next) && !full_next);
    end

    // Hold indices, flag and length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_W'(LEN_INIT);
            wr_reg   <= '0;
            rd_reg   <= '0;
            full_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            len_reg  <= len_cfg;
            wr_reg   <= '0;
            rd_reg   <= '0;
            full_reg <= 1'b0;
        end
        else if (fire)
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            full_reg <= full_next;
        end
    end

    // Result valid: set on a step, drop when taken
    assign out_valid_next = fire || (out_valid_reg && !res_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Byte store write and registered read into the result
    always_ff @(posedge clk)
    begin
        if (fire && store_we)
        begin
            store_mem[wr_reg] <= item.write_byte;
        end
        if (fire)
        begin
            res_reg.read_data   <= rvalid_next ? store_mem[rd_reg] : '0;
            res_reg.read_valid  <= rvalid_next;
            res_reg.not_empty   <= not_empty_next;
            res_reg.enough_data <= enough_next;
            res_reg.full_res    <= full_next;
        end
    end

    assign res_ch.valid = out_valid_reg;
    assign res_ch.item  = res_reg;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (LEN_W'(wr_reg) < len_reg) && (LEN_W'(rd_reg) < len_reg))
        else $error("ring index beyond buffer length");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (wr_reg == '0) && (rd_reg == '0) && !full_reg)
        else $error("length write did not clear indices");

    a_no_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.read_valid) |-> (res_reg.read_data == '0))
        else $error("read data nonzero without a valid read");

    a_step_after_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && need_rem) |-> rem_status.done)
        else $error("set position stepped before remainder ready");
`endif

endmodule

// File: hdl/overwrite_ring_buffer.sv
// Top level of the overwrite ring buffer.
`timescale 1ns / 1ps

// Byte ring buffer that overwrites its oldest byte when full. Each command
// item (write, read, set write position, status) yields exactly one result
// item, registered in order: the accepting edge loads the input register,
// and the step that takes it loads the index update and byte store access
// into the result register. Commands are taken at one item per cycle while
// results are taken and no set-position command waits for the remainder
// unit; a result that waits stalls the input once the input register holds
// one more item. A set-position command whose position is at least twice
// the buffer length is wrapped by a bit-serial remainder unit; positions
// from the length below that wrap with a single subtract. The byte store
// is not cleared after reset; reading a never-written entry returns an
// undefined byte. Writing buffer_length (cfg_we/cfg_data) clears both
// indices and the full flag and must happen while no item is in flight.
// Lengths of 0 act as 1 and lengths above STORE_DEPTH act as STORE_DEPTH.
module overwrite_ring_buffer #(
    parameter int STORE_DEPTH = orb_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [orb_pkg::BYTE_W-1:0] cfg_data,
    orb_in_if.sink                     cmd_ch,
    orb_out_if.source                  res_ch
);
    import orb_pkg::*;

    localparam int LEN_W = $clog2(STORE_DEPTH + 1);

    logic             item_valid;
    in_item_t         item;
    logic             take;
    logic             rem_start;
    logic [LEN_W-1:0] divisor;
    logic [LEN_W-1:0] rem_value;
    rem_stat_t        rem_status;

    // Hold the accepted command item
    orb_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_ch     (cmd_ch),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Wrap large positions bit-serially
    orb_rem_unit #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_rem_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .clear     (take),
        .dividend  (item.position),
        .divisor   (divisor),
        .remainder (rem_value),
        .status    (rem_status)
    );

    // Update indices and store, produce the result item
    orb_core #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .rem_start  (rem_start),
        .divisor    (divisor),
        .rem_value  (rem_value),
        .rem_status (rem_status),
        .res_ch     (res_ch)
    );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench of the overwrite ring buffer with an in-line ring predictor.
`timescale 1ns / 1ps

module tb_top;
    import orb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 37;

    // Track the ring indices, the full flag and the bytes, and queue the expected results
    class ring_scoreboard;
        logic [BYTE_W-1:0] store [DEPTH_DEFAULT];
        bit                written [DEPTH_DEFAULT];
        int                wr_idx;
        int                rd_idx;
        bit                full;
        logic [BYTE_W-1:0] length_reg;
        out_item_t         expected_q [$];
        int                errors;

        function new();
            wr_idx     = 0;
            rd_idx     = 0;
            full       = 1'b0;
            length_reg = BYTE_W'(LEN_RESET);
            errors     = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function int length_in_use();
            if (length_reg == 0)
                return 1;
            if (int'(length_reg) > DEPTH_DEFAULT)
                return DEPTH_DEFAULT;
            return int'(length_reg);
        endfunction

        function int step_index(int i, int n);
            return (i + 1 >= n) ? 0 : i + 1;
        endfunction

        // Clear both indices and the full flag; the stored bytes stay
        function void set_length(logic [BYTE_W-1:0] value);
            length_reg = value;
            wr_idx     = 0;
            rd_idx     = 0;
            full       = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // True when this read would return a byte that was never stored
        function bit reads_unwritten(in_item_t it);
            int n;
            int rd;
            int wr;
            n  = length_in_use();
            rd = (rd_idx >= n) ? 0 : rd_idx;
            wr = (wr_idx >= n) ? 0 : wr_idx;
            if (it.command != CMD_READ)
                return 1'b0;
            if (rd == wr && !full)
                return 1'b0;
            return !written[rd];
        endfunction

        // Apply one accepted command to the ring and queue its result
        function void note_command(in_item_t it);
            int        n;
            int        target;
            int        need;
            int        distance;
            out_item_t res;
            n = length_in_use();
            if (wr_idx >= n) wr_idx = 0;
            if (rd_idx >= n) rd_idx = 0;
            res = '0;
            case (it.command)
                CMD_WRITE:
                begin
                    store[wr_idx]   = it.write_byte;
                    written[wr_idx] = 1'b1;
                    wr_idx = step_index(wr_idx, n);
                    if (rd_idx == wr_idx) full = 1'b1;
                    // Drag the oldest byte along while full
                    if (full) rd_idx = wr_idx;
                end
                CMD_READ:
                begin
                    if (rd_idx != wr_idx || full)
                    begin
                        if (rd_idx == wr_idx) full = 1'b0;
                        res.read_data  = store[rd_idx];
                        res.read_valid = 1'b1;
                        rd_idx = step_index(rd_idx, n);
                    end
                end
                CMD_SETPOS:
                begin
                    // Wrap the position and push the read index past the skipped span
                    if (int'(it.position) >= n)
                    begin
                        target = int'(it.position) % n;
                        if (rd_idx < target || rd_idx >= wr_idx)
                            rd_idx = step_index(target, n);
                    end
                    else
                    begin
                        target = int'(it.position);
                        if (rd_idx < target && rd_idx >= wr_idx)
                            rd_idx = step_index(target, n);
                    end
                    wr_idx = target;
                end
                default: ;
            endcase
            need = int'(it.header_count) + (int'(it.item_count) * int'(it.item_bits)) / 8;
            distance = (wr_idx >= rd_idx) ? wr_idx - rd_idx : n - rd_idx + wr_idx;
            res.not_empty   = !(rd_idx == wr_idx && !full);
            res.enough_data = (distance >= need);
            res.full_res    = full;
            expected_q.push_back(res);
        endfunction

        function void report(string name, int exp_val, int got_val);
            if (exp_val != got_val)
            begin
                $error("%s: expected %0h, got %0h", name, exp_val, got_val);
                errors++;
            end
        endfunction

        // Compare one result against the oldest expectation
        function void check_result(out_item_t got);
            out_item_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("result item with no command waiting: %0h", got);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            report("read_data", exp_res.read_data, got.read_data);
            report("read_valid", exp_res.read_valid, got.read_valid);
            report("not_empty", exp_res.not_empty, got.not_empty);
            report("enough_data", exp_res.enough_data, got.enough_data);
            report("full_res", exp_res.full_res, got.full_res);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [BYTE_W-1:0] cfg_data;
    bit                steady_run;
    int                cycle_count;
    ring_scoreboard    sb;

    orb_in_if  cmd_if ();
    orb_out_if res_if ();

    overwrite_ring_buffer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd_ch   (cmd_if),
        .res_ch   (res_if)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the result side at random, except during a steady stretch
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_if.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check every accepted result item
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.item);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Present one command, hold it until accepted, and note it
    task automatic send_command(in_item_t it);
        if (sb.reads_unwritten(it))
            it.command = CMD_STATUS;
        while (!steady_run && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.item  <= it;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        sb.note_command(it);
        @(negedge clk);
    endtask

    task automatic send_fields(cmd_t c, int wb, int pos, int hdr, int cnt, int bits);
        in_item_t it;
        it.command      = c;
        it.write_byte   = wb[BYTE_W-1:0];
        it.position     = pos[POS_W-1:0];
        it.header_count = hdr[BYTE_W-1:0];
        it.item_count   = cnt[BYTE_W-1:0];
        it.item_bits    = bits[BYTE_W-1:0];
        send_command(it);
    endtask

    // Drop valid and wait until every result item has come back
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_length(int value);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= value[BYTE_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_length(value[BYTE_W-1:0]);
        @(negedge clk);
    endtask

    // Draw a command with the given mix; keep sizes mostly small so both check outcomes occur
    function automatic in_item_t random_command(int wr_pct, int rd_pct, int sp_pct);
        in_item_t it;
        int       n;
        int       r;
        int       sel;
        n = sb.length_in_use();
        r = $urandom_range(0, 99);
        if (r < wr_pct)
            it.command = CMD_WRITE;
        else if (r < wr_pct + rd_pct)
            it.command = CMD_READ;
        else if (r < wr_pct + rd_pct + sp_pct)
            it.command = CMD_SETPOS;
        else
            it.command = CMD_STATUS;
        it.write_byte = BYTE_W'($urandom_range(0, 255));
        sel = $urandom_range(0, 9);
        if (sel < 6)
            it.position = POS_W'($urandom_range(0, n - 1));
        else if (sel < 9 || 2 * n > 509)
            it.position = POS_W'($urandom_range(n, (2 * n - 1 > 509) ? 509 : 2 * n - 1));
        else
            it.position = POS_W'($urandom_range(2 * n, 509));
        it.header_count = BYTE_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 8)
                                                             : $urandom_range(0, 255));
        it.item_count   = BYTE_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 8)
                                                             : $urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0: it.item_bits = BYTE_W'(8);
            1: it.item_bits = BYTE_W'(16);
            2: it.item_bits = BYTE_W'(32);
            default: it.item_bits = BYTE_W'($urandom_range(0, 255));
        endcase
        return it;
    endfunction

    // Set the length, then run random commands with one full pause midway
    task automatic run_phase(int length, int count, int wr_pct, int rd_pct, int sp_pct,
                             bit with_steady);
        write_length(length);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain();
            steady_run = with_steady && (i >= 100) && (i < 200);
            send_command(random_command(wr_pct, rd_pct, sp_pct));
        end
        steady_run = 1'b0;
    endtask

    // Corner cases: empty read, full overwrite, read from full, every wrap of set-position
    task automatic run_directed();
        send_fields(CMD_READ, 0, 0, 0, 0, 0);
        send_fields(CMD_STATUS, 0, 0, 0, 0, 0);
        send_fields(CMD_WRITE, 255, 0, 0, 0, 0);
        send_fields(CMD_STATUS, 0, 0, 255, 255, 255);
        send_fields(CMD_READ, 0, 0, 0, 0, 0);
        write_length(3);
        send_fields(CMD_WRITE, 0, 0, 0, 0, 8);
        send_fields(CMD_WRITE, 8'hA5, 0, 0, 1, 8);
        send_fields(CMD_WRITE, 8'h5A, 0, 0, 0, 8);
        send_fields(CMD_STATUS, 0, 0, 1, 0, 8);
        send_fields(CMD_WRITE, 8'h3C, 0, 0, 0, 0);
        send_fields(CMD_READ, 0, 0, 0, 1, 16);
        send_fields(CMD_READ, 0, 0, 0, 0, 0);
        send_fields(CMD_READ, 0, 0, 0, 0, 0);
        send_fields(CMD_READ, 0, 0, 0, 0, 0);
        send_fields(CMD_SETPOS, 0, 1, 0, 0, 0);
        send_fields(CMD_SETPOS, 0, 4, 0, 0, 0);
        send_fields(CMD_SETPOS, 0, 509, 0, 0, 0);
        send_fields(CMD_SETPOS, 0, 0, 0, 0, 0);
        send_fields(CMD_WRITE, 8'h81, 0, 0, 0, 0);
        send_fields(CMD_SETPOS, 0, 2, 0, 0, 0);
        send_fields(CMD_READ, 0, 0, 0, 1, 16);
        send_fields(CMD_WRITE, 8'h42, 0, 0, 0, 0);
        send_fields(CMD_WRITE, 8'h24, 0, 0, 0, 0);
        send_fields(CMD_WRITE, 8'h99, 0, 0, 0, 0);
        send_fields(CMD_SETPOS, 0, 5, 0, 2, 8);
    endtask

    // Reset once, then directed corners and random phases over several lengths
    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        cmd_if.valid = 1'b0;
        cmd_if.item  = '0;
        steady_run   = 1'b0;
        cycle_count  = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_phase(255, 300, 75, 15, 3, 1'b1);
        run_phase(1, 50, 40, 40, 10, 1'b0);
        run_phase(2, 50, 40, 40, 10, 1'b0);
        run_phase($urandom_range(3, 12), 80, 40, 35, 12, 1'b0);
        run_phase($urandom_range(13, 254), 90, 45, 35, 8, 1'b0);
        run_phase(255, 80, 40, 40, 10, 1'b0);

        drain();
        repeat (10) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
